// ===== design/ray_segment_hit_distance_defines.svh =====
// assertion macros for the probe versus wall intersection block
// used by ray_segment_hit_distance; no other dependencies
`ifndef RAY_SEGMENT_HIT_DISTANCE_DEFINES_SVH
`define RAY_SEGMENT_HIT_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define RSHD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ray_segment_hit_distance: check failed");
// checked during reset as well
`define RSHD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("ray_segment_hit_distance: reset check failed");
`else
`define RSHD_ASSERT(label, prop)
`define RSHD_ASSERT_RST(label, prop)
`endif
`endif

// ===== design/rshd_pkg.sv =====
// shared types and widths for the probe versus wall intersection pipeline
// no dependencies
package rshd_pkg;

    localparam int CRD_W  = 20;  // coordinate
    localparam int DIF_W  = 21;  // coordinate difference
    localparam int PRD_W  = 42;  // product of two differences
    localparam int SGN_W  = 44;  // signed cross product sum
    localparam int MAG_W  = 43;  // magnitude of denominator and numerator
    localparam int LO_W   = 22;  // low slice of numerator for split multiply
    localparam int QUO_W  = 21;  // offset quotient
    localparam int NUM_W  = 64;  // dividend width
    localparam int ROOT_W = 22;  // square root result
    localparam int SUM_W  = 44;  // sum of squares
    localparam int DIST_W = 19;
    localparam int unsigned DIST_MAX = 524287;

    typedef struct packed {
        logic signed [CRD_W-1:0] probe_start_x;
        logic signed [CRD_W-1:0] probe_start_y;
        logic signed [CRD_W-1:0] probe_end_x;
        logic signed [CRD_W-1:0] probe_end_y;
        logic signed [CRD_W-1:0] wall_start_x;
        logic signed [CRD_W-1:0] wall_start_y;
        logic signed [CRD_W-1:0] wall_end_x;
        logic signed [CRD_W-1:0] wall_end_y;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } out_item_t;

    // control that travels with each item
    typedef struct packed {
        logic valid;
        logic hit;
    } ctl_t;

endpackage

// ===== design/rshd_front.sv =====
// front end: differences, cross products, hit test and dividend build
// depends on rshd_pkg
module rshd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  rshd_pkg::in_item_t            in_data,
    output rshd_pkg::ctl_t                ctl_out,
    output logic [rshd_pkg::MAG_W-1:0]    den_out,
    output logic [rshd_pkg::NUM_W-1:0]    num_x_out,
    output logic [rshd_pkg::NUM_W-1:0]    num_y_out
);
    import rshd_pkg::*;

    logic [4:0] vld_reg;
    ctl_t       ctl_reg;

    // stage 1: differences
    logic signed [DIF_W-1:0] dx_reg, dy_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    // stage 2: products and magnitudes
    logic signed [PRD_W-1:0] pd1_reg, pd2_reg, pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic [DIF_W-1:0]        adx2_reg, ady2_reg;
    // stage 3: cross sums
    logic signed [SGN_W-1:0] den3_reg, na3_reg, nb3_reg;
    logic [DIF_W-1:0]        adx3_reg, ady3_reg;
    // stage 4: sign normalised
    logic signed [SGN_W-1:0] den4_reg, na4_reg, nb4_reg;
    logic [DIF_W-1:0]        adx4_reg, ady4_reg;
    // stage 5: hit and partial products
    logic                    hit5_reg;
    logic [MAG_W-1:0]        den5_reg;
    logic [LO_W+DIF_W-1:0]   plx_reg, ply_reg;
    logic [MAG_W-LO_W+DIF_W-1:0] phx_reg, phy_reg;
    // stage 6
    logic [MAG_W-1:0]        den6_reg;
    logic [NUM_W-1:0]        nx6_reg, ny6_reg;

    logic [4:0] vld_next;
    ctl_t       ctl_next;
    logic       hit_next;

    assign vld_next = {vld_reg[3:0], in_valid};
    assign hit_next = (den4_reg != '0) && !na4_reg[SGN_W-1] && (na4_reg < den4_reg)
                      && !nb4_reg[SGN_W-1] && (nb4_reg < den4_reg);

    always_comb begin
        ctl_next.valid = vld_reg[4];
        ctl_next.hit   = hit5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            ctl_reg.valid <= 1'b0;
            ctl_reg.hit   <= 1'b0;
        end else if (ce) begin
            vld_reg <= vld_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg <= DIF_W'(in_data.probe_end_x) - DIF_W'(in_data.probe_start_x);
            dy_reg <= DIF_W'(in_data.probe_end_y) - DIF_W'(in_data.probe_start_y);
            ex_reg <= DIF_W'(in_data.wall_end_x) - DIF_W'(in_data.wall_start_x);
            ey_reg <= DIF_W'(in_data.wall_end_y) - DIF_W'(in_data.wall_start_y);
            fx_reg <= DIF_W'(in_data.probe_start_x) - DIF_W'(in_data.wall_start_x);
            fy_reg <= DIF_W'(in_data.probe_start_y) - DIF_W'(in_data.wall_start_y);

            pd1_reg  <= ey_reg * dx_reg;
            pd2_reg  <= ex_reg * dy_reg;
            pa1_reg  <= ex_reg * fy_reg;
            pa2_reg  <= ey_reg * fx_reg;
            pb1_reg  <= dx_reg * fy_reg;
            pb2_reg  <= dy_reg * fx_reg;
            adx2_reg <= dx_reg[DIF_W-1] ? DIF_W'(-dx_reg) : DIF_W'(dx_reg);
            ady2_reg <= dy_reg[DIF_W-1] ? DIF_W'(-dy_reg) : DIF_W'(dy_reg);

            den3_reg <= SGN_W'(pd1_reg) - SGN_W'(pd2_reg);
            na3_reg  <= SGN_W'(pa1_reg) - SGN_W'(pa2_reg);
            nb3_reg  <= SGN_W'(pb1_reg) - SGN_W'(pb2_reg);
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;

            // make the denominator non-negative
            den4_reg <= den3_reg[SGN_W-1] ? -den3_reg : den3_reg;
            na4_reg  <= den3_reg[SGN_W-1] ? -na3_reg  : na3_reg;
            nb4_reg  <= den3_reg[SGN_W-1] ? -nb3_reg  : nb3_reg;
            adx4_reg <= adx3_reg;
            ady4_reg <= ady3_reg;

            hit5_reg <= hit_next;
            den5_reg <= den4_reg[MAG_W-1:0];
            plx_reg  <= na4_reg[LO_W-1:0] * adx4_reg;
            ply_reg  <= na4_reg[LO_W-1:0] * ady4_reg;
            phx_reg  <= na4_reg[MAG_W-1:LO_W] * adx4_reg;
            phy_reg  <= na4_reg[MAG_W-1:LO_W] * ady4_reg;

            den6_reg <= den5_reg;
            nx6_reg  <= {phx_reg, {LO_W{1'b0}}} + NUM_W'(plx_reg);
            ny6_reg  <= {phy_reg, {LO_W{1'b0}}} + NUM_W'(ply_reg);
        end
    end

    assign ctl_out   = ctl_reg;
    assign den_out   = den6_reg;
    assign num_x_out = nx6_reg;
    assign num_y_out = ny6_reg;

endmodule

// ===== design/rshd_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor; depends on rshd_pkg
module rshd_div_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  rshd_pkg::ctl_t                ctl_in,
    input  logic [rshd_pkg::MAG_W-1:0]    den_in,
    input  logic [rshd_pkg::NUM_W-1:0]    num_x_in,
    input  logic [rshd_pkg::NUM_W-1:0]    num_y_in,
    output rshd_pkg::ctl_t                ctl_out,
    output logic [rshd_pkg::QUO_W-1:0]    q_x_out,
    output logic [rshd_pkg::QUO_W-1:0]    q_y_out
);
    import rshd_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] den;
        logic [MAG_W-1:0] rx;
        logic [MAG_W-1:0] ry;
        logic [QUO_W-1:0] nx;
        logic [QUO_W-1:0] ny;
        logic [QUO_W-1:0] qx;
        logic [QUO_W-1:0] qy;
    } div_stage_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] q;
    } step_t;

    function automatic step_t div_step(input logic [MAG_W-1:0] rem, input logic nb,
                                       input logic [QUO_W-1:0] q,
                                       input logic [MAG_W-1:0] d);
        logic [MAG_W:0] t;
        logic [MAG_W:0] s;
        step_t          r;
        t = {rem, nb};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            r.rem = s[MAG_W-1:0];
            r.q   = {q[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[MAG_W-1:0];
            r.q   = {q[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    div_stage_t stage_reg [0:QUO_W-1];
    ctl_t       ctl_reg   [0:QUO_W-1];
    div_stage_t stage_in  [0:QUO_W-1];
    ctl_t       ctl_src   [0:QUO_W-1];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        div_stage_t st_next;
        step_t      sx, sy;

        if (i == 0) begin : g_first
            always_comb begin
                stage_in[i].den = den_in;
                stage_in[i].rx  = num_x_in[NUM_W-1:QUO_W];
                stage_in[i].ry  = num_y_in[NUM_W-1:QUO_W];
                stage_in[i].nx  = num_x_in[QUO_W-1:0];
                stage_in[i].ny  = num_y_in[QUO_W-1:0];
                stage_in[i].qx  = '0;
                stage_in[i].qy  = '0;
            end
            assign ctl_src[i] = ctl_in;
        end else begin : g_next
            assign stage_in[i] = stage_reg[i-1];
            assign ctl_src[i]  = ctl_reg[i-1];
        end

        always_comb begin
            sx = div_step(stage_in[i].rx, stage_in[i].nx[QUO_W-1], stage_in[i].qx,
                          stage_in[i].den);
            sy = div_step(stage_in[i].ry, stage_in[i].ny[QUO_W-1], stage_in[i].qy,
                          stage_in[i].den);
            st_next.den = stage_in[i].den;
            st_next.rx  = sx.rem;
            st_next.ry  = sy.rem;
            st_next.qx  = sx.q;
            st_next.qy  = sy.q;
            st_next.nx  = {stage_in[i].nx[QUO_W-2:0], 1'b0};
            st_next.ny  = {stage_in[i].ny[QUO_W-2:0], 1'b0};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i].valid <= 1'b0;
                ctl_reg[i].hit   <= 1'b0;
            end else if (ce) begin
                ctl_reg[i] <= ctl_src[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                stage_reg[i] <= st_next;
            end
        end
    end

    assign ctl_out = ctl_reg[QUO_W-1];
    assign q_x_out = stage_reg[QUO_W-1].qx;
    assign q_y_out = stage_reg[QUO_W-1].qy;

endmodule

// ===== design/rshd_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
// depends on rshd_pkg
module rshd_sqrt_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  rshd_pkg::ctl_t                ctl_in,
    input  logic [rshd_pkg::SUM_W-1:0]    val_in,
    output rshd_pkg::ctl_t                ctl_out,
    output logic [rshd_pkg::ROOT_W-1:0]   root_out
);
    import rshd_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    typedef struct packed {
        logic [SUM_W-1:0]  v;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_stage_t;

    sq_stage_t stage_reg [0:ROOT_W-1];
    ctl_t      ctl_reg   [0:ROOT_W-1];
    sq_stage_t stage_in  [0:ROOT_W-1];
    ctl_t      ctl_src   [0:ROOT_W-1];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        sq_stage_t        st_next;
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;

        if (i == 0) begin : g_first
            always_comb begin
                stage_in[i].v    = val_in;
                stage_in[i].rem  = '0;
                stage_in[i].root = '0;
            end
            assign ctl_src[i] = ctl_in;
        end else begin : g_next
            assign stage_in[i] = stage_reg[i-1];
            assign ctl_src[i]  = ctl_reg[i-1];
        end

        always_comb begin
            t     = {stage_in[i].rem, stage_in[i].v[SUM_W-1:SUM_W-2]};
            trial = (REM_W+2)'({stage_in[i].root, 2'b01});
            diff  = t - trial;
            st_next.v = {stage_in[i].v[SUM_W-3:0], 2'b00};
            if (t >= trial) begin
                st_next.rem  = diff[REM_W-1:0];
                st_next.root = {stage_in[i].root[ROOT_W-2:0], 1'b1};
            end else begin
                st_next.rem  = t[REM_W-1:0];
                st_next.root = {stage_in[i].root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i].valid <= 1'b0;
                ctl_reg[i].hit   <= 1'b0;
            end else if (ce) begin
                ctl_reg[i] <= ctl_src[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                stage_reg[i] <= st_next;
            end
        end
    end

    assign ctl_out  = ctl_reg[ROOT_W-1];
    assign root_out = stage_reg[ROOT_W-1].root;

endmodule

// ===== design/ray_segment_hit_distance.sv =====
// throughput: one item per cycle; the whole pipeline advances together
// and holds while a finished result waits for m_ready
// reset: synchronous, aresetn low clears every stage valid bit and the output
// register; payload registers are not reset
`include "ray_segment_hit_distance_defines.svh"
module ray_segment_hit_distance #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rshd_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rshd_pkg::out_item_t   m_data
);
    import rshd_pkg::*;

    // 2000.0 in the coordinate scale, clipped to the distance field
    localparam longint unsigned NOHIT_RAW = 64'(2000) << COORD_FRAC_BITS;
    localparam logic [DIST_W-1:0] NOHIT_DIST =
        (NOHIT_RAW > 64'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(NOHIT_RAW);

    // pipeline advance: output register empty or being drained
    logic ce;

    // front end: diffs, cross products, sign fix, hit test, dividends (6 stages)
    ctl_t              fe_ctl;
    logic [MAG_W-1:0]  fe_den;
    logic [NUM_W-1:0]  fe_num_x, fe_num_y;

    // divider: offsets mx and my along the probe (21 stages)
    ctl_t              dv_ctl;
    logic [QUO_W-1:0]  dv_mx, dv_my;

    // squares then their sum (2 stages)
    ctl_t              sq_ctl_reg, sum_ctl_reg;
    logic [2*QUO_W-1:0] sqx_reg, sqy_reg;
    logic [SUM_W-1:0]  sum_reg;

    // square root (22 stages)
    ctl_t              rt_ctl;
    logic [ROOT_W-1:0] rt_root;

    // output register
    logic              m_valid_reg;
    out_item_t         m_data_reg;
    out_item_t         m_data_next;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    rshd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .ctl_out   (fe_ctl),
        .den_out   (fe_den),
        .num_x_out (fe_num_x),
        .num_y_out (fe_num_y)
    );

    rshd_div_pipe u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .ctl_in   (fe_ctl),
        .den_in   (fe_den),
        .num_x_in (fe_num_x),
        .num_y_in (fe_num_y),
        .ctl_out  (dv_ctl),
        .q_x_out  (dv_mx),
        .q_y_out  (dv_my)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_ctl_reg.valid  <= 1'b0;
            sq_ctl_reg.hit    <= 1'b0;
            sum_ctl_reg.valid <= 1'b0;
            sum_ctl_reg.hit   <= 1'b0;
        end else if (ce) begin
            sq_ctl_reg  <= dv_ctl;
            sum_ctl_reg <= sq_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sqx_reg <= dv_mx * dv_mx;
            sqy_reg <= dv_my * dv_my;
            sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        end
    end

    rshd_sqrt_pipe u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .ctl_in   (sum_ctl_reg),
        .val_in   (sum_reg),
        .ctl_out  (rt_ctl),
        .root_out (rt_root)
    );

    // saturate a hit distance; a miss takes the sentinel
    always_comb begin
        m_data_next.hit = rt_ctl.hit;
        if (!rt_ctl.hit) begin
            m_data_next.distance = NOHIT_DIST;
        end else if (rt_root > ROOT_W'(DIST_MAX)) begin
            m_data_next.distance = DIST_W'(DIST_MAX);
        end else begin
            m_data_next.distance = rt_root[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= rt_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a miss always carries the sentinel distance
    `RSHD_ASSERT(a_miss_dist, m_valid && !m_data.hit |-> m_data.distance == NOHIT_DIST)
    // input side only stalls behind a waiting result
    `RSHD_ASSERT(a_stall_cause, !s_ready |-> m_valid)
    // reset empties the output register
    `RSHD_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)

endmodule
